// ===== hdl/ilid_pkg.sv =====
// ilid_pkg: shared codes, field widths and controller/datapath handshake structs
// for the indexed list block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ilid_pkg;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REMOVE_FRONT = 2'd0,
        FUNC_INSERT_FRONT = 2'd1,
        FUNC_DELETE_AT    = 2'd2,
        FUNC_INSERT_AT    = 2'd3
    } func_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic finish;
        logic prime;
        logic emit;
        logic advance;
    } ilid_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic shift_done;
        logic emit_last;
    } ilid_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ilid_if.sv =====
// ilid request and response channel interfaces (valid/ready with payload)
// depends on ilid_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ilid_req_if
    import ilid_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, func, position, item_value, input ready);
    modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface ilid_rsp_if
    import ilid_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last_entry;
    logic                      list_empty;
    logic                      insert_dropped;

    modport source (output valid, entry_value, last_entry, list_empty, insert_dropped,
                    input ready);
    modport sink   (input valid, entry_value, last_entry, list_empty, insert_dropped,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/ilid_ctrl.sv =====
// ilid_ctrl: request sequencing state machine (accept, shift, prime, list)
// depends on ilid_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilid_ctrl
    import ilid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output ilid_cmd_t       cmd,
    input  wire ilid_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PRIME,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    if (stat.shift_done)
                    begin
                        state_reg <= ST_PRIME;
                    end
                end
                ST_PRIME:
                begin
                    state_reg     <= ST_EMIT;
                    rsp_valid_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (rsp_ready && stat.emit_last)
                    begin
                        state_reg     <= ST_IDLE;
                        rsp_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    rsp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.load    = (state_reg == ST_IDLE) && req_valid;
        cmd.shift   = (state_reg == ST_SHIFT);
        cmd.finish  = (state_reg == ST_SHIFT) && stat.shift_done;
        cmd.prime   = (state_reg == ST_PRIME);
        cmd.emit    = (state_reg == ST_EMIT);
        cmd.advance = (state_reg == ST_EMIT) && rsp_ready && !stat.emit_last;
    end

endmodule

`default_nettype wire

// ===== hdl/ilid_dpath.sv =====
// ilid_dpath: list memory, length, shift pointers and listing index
// depends on ilid_pkg; driven by ilid_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module ilid_dpath
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ilid_cmd_t                 cmd,
    output ilid_stat_t                     stat,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic [POS_W-1:0]          position,
    input  wire logic signed [VALUE_W-1:0] item_value,
    output logic signed [VALUE_W-1:0]      entry_value,
    output logic                           last_entry,
    output logic                           list_empty,
    output logic                           insert_dropped
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    logic [LW-1:0]      len_reg, len_next;
    logic               pend_reg;
    logic [LW-1:0]      wa_reg;
    logic [LW-1:0]      cnt_reg;
    logic [LW-1:0]      rp_reg;
    logic [LW-1:0]      p_reg;
    logic [LW-1:0]      eidx_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               ins_reg;
    logic               do_ins_reg;
    logic               do_del_reg;
    logic               dropped_reg;

    // request decode
    logic          at_front, is_ins, full;
    logic [CW-1:0] pos_ext, len_ext, ins_pos;
    logic [LW-1:0] p_new;
    logic          do_ins_new, do_del_new;

    always_comb
    begin
        at_front   = (func == FUNC_REMOVE_FRONT) || (func == FUNC_INSERT_FRONT);
        is_ins     = (func == FUNC_INSERT_FRONT) || (func == FUNC_INSERT_AT);
        full       = (len_reg == LW'(CAPACITY));
        pos_ext    = at_front ? '0 : CW'(position);
        len_ext    = CW'(len_reg);
        ins_pos    = (pos_ext > len_ext) ? len_ext : pos_ext;
        p_new      = is_ins ? ins_pos[LW-1:0] : pos_ext[LW-1:0];
        do_ins_new = is_ins && !full;
        do_del_new = !is_ins && (pos_ext < len_ext);
    end

    // memory port control
    logic               re, we;
    logic [IW-1:0]      ra, wa;
    logic [VALUE_W-1:0] wd;
    logic               shift_move;
    logic [LW-1:0]      eidx_inc;

    always_comb
    begin
        shift_move = cmd.shift && (cnt_reg != '0);
        eidx_inc   = eidx_reg + LW'(1);
        re         = shift_move || cmd.prime || cmd.emit;
        if (cmd.shift)
        begin
            ra = rp_reg[IW-1:0];
        end
        else if (cmd.prime)
        begin
            ra = '0;
        end
        else if (cmd.advance)
        begin
            ra = eidx_inc[IW-1:0];
        end
        else
        begin
            ra = eidx_reg[IW-1:0];
        end
        if (pend_reg)
        begin
            we = 1'b1;
            wa = wa_reg[IW-1:0];
            wd = rdata_reg;
        end
        else
        begin
            we = cmd.finish && do_ins_reg;
            wa = p_reg[IW-1:0];
            wd = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rdata_reg <= mem[ra];
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.finish && do_ins_reg)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (cmd.finish && do_del_reg)
        begin
            len_next = len_reg - LW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            pend_reg <= shift_move;
            if (cmd.load)
            begin
                if (do_ins_new)
                begin
                    cnt_reg <= len_reg - p_new;
                end
                else if (do_del_new)
                begin
                    cnt_reg <= len_reg - p_new - LW'(1);
                end
                else
                begin
                    cnt_reg <= '0;
                end
            end
            else if (shift_move)
            begin
                cnt_reg <= cnt_reg - LW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg       <= p_new;
            val_reg     <= item_value;
            ins_reg     <= is_ins;
            do_ins_reg  <= do_ins_new;
            do_del_reg  <= do_del_new;
            dropped_reg <= is_ins && full;
            rp_reg      <= is_ins ? (len_reg - LW'(1)) : (p_new + LW'(1));
        end
        else if (shift_move)
        begin
            rp_reg <= ins_reg ? (rp_reg - LW'(1)) : (rp_reg + LW'(1));
            wa_reg <= ins_reg ? (rp_reg + LW'(1)) : (rp_reg - LW'(1));
        end
        if (cmd.prime)
        begin
            eidx_reg <= '0;
        end
        else if (cmd.advance)
        begin
            eidx_reg <= eidx_inc;
        end
    end

    always_comb
    begin
        stat.shift_done = (cnt_reg == '0) && !pend_reg;
        stat.emit_last  = (len_reg == '0) || (eidx_inc == len_reg);
    end

    assign list_empty     = (len_reg == '0);
    assign entry_value    = list_empty ? '0 : rdata_reg;
    assign last_entry     = stat.emit_last;
    assign insert_dropped = dropped_reg;

endmodule

`default_nettype wire

// ===== hdl/indexed_list_insert_delete.sv =====
// indexed_list_insert_delete: ordered list with insert/delete at a position
// an accepted request first moves the entries at or after its position, up to CAPACITY-1 moves,
// then primes the first read and lists every entry; the list memory has a single read and write port
// throughput: one result per cycle while listing and rsp.ready is high; a new request is accepted
// only once the last entry of the listing has been taken
// reset: list length cleared to zero, no result pending, memory contents left as is
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ilid_req_if.sink   req,
    ilid_rsp_if.source rsp
);

    ilid_cmd_t  cmd;
    ilid_stat_t stat;

    ilid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ilid_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (req.func),
        .position       (req.position),
        .item_value     (req.item_value),
        .entry_value    (rsp.entry_value),
        .last_entry     (rsp.last_entry),
        .list_empty     (rsp.list_empty),
        .insert_dropped (rsp.insert_dropped)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for indexed_list_insert_delete
// keeps a shadow copy of the list, predicts every listing and checks each result transfer
// depends on ilid_pkg and the ilid_req_if / ilid_rsp_if interfaces
`timescale 1ns / 1ps

module tb;
    import ilid_pkg::*;

    localparam int          CAPACITY     = 32;
    localparam int          HALF_PERIOD  = 4;
    localparam int          IDLE_PCT     = 6;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 41;

    typedef struct {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last_entry;
        logic                      list_empty;
        logic                      insert_dropped;
    } listing_entry_t;

    class list_scoreboard;
        logic signed [VALUE_W-1:0] shadow[CAPACITY];
        int                        length;
        listing_entry_t            listing_q[$];
        int                        errors;

        function new();
            length = 0;
            errors = 0;
        endfunction

        function void drop_entry(int at);
            if (at >= length)
                return;
            for (int i = at; i + 1 < length; i++)
                shadow[i] = shadow[i + 1];
            length--;
        endfunction

        function bit place_entry(int at, logic signed [VALUE_W-1:0] value);
            if (length >= CAPACITY)
                return 1'b0;
            if (at > length)
                at = length;
            for (int i = length; i > at; i--)
                shadow[i] = shadow[i - 1];
            shadow[at] = value;
            length++;
            return 1'b1;
        endfunction

        // apply an accepted request and queue the listing it causes
        function void note_request(func_t f, logic [POS_W-1:0] pos,
                                   logic signed [VALUE_W-1:0] value);
            bit             dropped;
            listing_entry_t e;
            dropped = 1'b0;
            case (f)
                FUNC_REMOVE_FRONT: drop_entry(0);
                FUNC_INSERT_FRONT: dropped = !place_entry(0, value);
                FUNC_DELETE_AT:    drop_entry(int'(pos));
                default:           dropped = !place_entry(int'(pos), value);
            endcase
            if (length == 0)
            begin
                e = '{entry_value: '0, last_entry: 1'b1, list_empty: 1'b1,
                      insert_dropped: dropped};
                listing_q.push_back(e);
            end
            else
            begin
                for (int k = 0; k < length; k++)
                begin
                    e = '{entry_value: shadow[k], last_entry: (k + 1 == length),
                          list_empty: 1'b0, insert_dropped: dropped};
                    listing_q.push_back(e);
                end
            end
        endfunction

        function void check_entry(logic signed [VALUE_W-1:0] value, logic last,
                                  logic empty, logic dropped);
            listing_entry_t e;
            if (listing_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("tb: unexpected result value=%0d last=%b empty=%b dropped=%b",
                             value, last, empty, dropped);
                return;
            end
            e = listing_q.pop_front();
            if (value !== e.entry_value || last !== e.last_entry ||
                empty !== e.list_empty || dropped !== e.insert_dropped)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("tb: mismatch exp value=%0d last=%b empty=%b dropped=%b,",
                           e.entry_value, e.last_entry, e.list_empty, e.insert_dropped);
                    $display(" got value=%0d last=%b empty=%b dropped=%b",
                             value, last, empty, dropped);
                end
            end
        endfunction

        function int pending();
            return listing_q.size();
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    bit             no_idle;
    int unsigned    cycles;
    list_scoreboard sb;

    ilid_req_if req ();
    ilid_rsp_if rsp ();

    indexed_list_insert_delete #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_entry(rsp.entry_value, rsp.last_entry, rsp.list_empty,
                           rsp.insert_dropped);
        rsp.ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_request(func_t f, logic [POS_W-1:0] pos,
                                logic signed [VALUE_W-1:0] value);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        req.valid      <= 1'b1;
        req.func       <= f;
        req.position   <= pos;
        req.item_value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(f, pos, value);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] corners[4];
        corners = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};
        if ($urandom_range(99) < 10)
            return corners[$urandom_range(3)];
        return signed'($urandom);
    endfunction

    // insert_pct steers the list length up or down
    task automatic random_request(int insert_pct);
        func_t            f;
        logic [POS_W-1:0] pos;
        if ($urandom_range(99) < insert_pct)
            f = ($urandom_range(1) == 0) ? FUNC_INSERT_FRONT : FUNC_INSERT_AT;
        else
            f = ($urandom_range(99) < 40) ? FUNC_REMOVE_FRONT : FUNC_DELETE_AT;
        if ($urandom_range(99) < 15)
            pos = POS_W'($urandom);
        else
            pos = POS_W'($urandom_range(sb.length + 1));
        if ($urandom_range(99) < 3)
            f = func_t'($urandom_range(3));
        send_request(f, pos, pick_value());
    endtask

    initial
    begin
        int phase_bias[7];
        phase_bias = '{90, 20, 85, 15, 60, 90, 30};
        clk            = 1'b0;
        rst_n          = 1'b0;
        no_idle        = 1'b0;
        cycles         = 0;
        req.valid      = 1'b0;
        req.func       = FUNC_REMOVE_FRONT;
        req.position   = '0;
        req.item_value = '0;
        rsp.ready      = 1'b0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners
        send_request(FUNC_REMOVE_FRONT, 6'd0, 32'sh0);
        send_request(FUNC_DELETE_AT, 6'd0, 32'sh0);
        send_request(FUNC_DELETE_AT, 6'd63, -32'sh1);
        // extremes, append past the length, middle inserts
        send_request(FUNC_INSERT_FRONT, 6'd63, 32'sh7fff_ffff);
        send_request(FUNC_INSERT_FRONT, 6'd0, 32'sh8000_0000);
        send_request(FUNC_INSERT_AT, 6'd63, -32'sh1);
        send_request(FUNC_INSERT_AT, 6'd0, 32'sh0);
        send_request(FUNC_INSERT_AT, 6'd2, 32'sh5555_5555);
        send_request(FUNC_INSERT_AT, 6'd32, 32'shaaaa_aaaa);
        send_request(FUNC_INSERT_AT, 6'd5, 32'sh0000_0001);
        // deletes at and past the length, last, front, middle
        send_request(FUNC_DELETE_AT, 6'd63, 32'sh0);
        send_request(FUNC_DELETE_AT, 6'(sb.length), 32'sh0);
        send_request(FUNC_DELETE_AT, 6'(sb.length - 1), 32'sh0);
        send_request(FUNC_DELETE_AT, 6'd0, 32'sh0);
        send_request(FUNC_DELETE_AT, 6'd1, 32'sh0);
        send_request(FUNC_REMOVE_FRONT, 6'd63, 32'sh7fff_ffff);
        send_request(FUNC_INSERT_FRONT, 6'd21, 32'sh1234_5678);
        // drain to empty, then one more remove
        while (sb.length > 0)
            send_request(FUNC_REMOVE_FRONT, 6'd0, 32'sh0);
        send_request(FUNC_REMOVE_FRONT, 6'd0, 32'sh0);

        for (int ph = 0; ph < 7; ph++)
        begin
            no_idle = (ph == 2);
            if (ph == 4)
            begin
                req.valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request(phase_bias[ph]);
        end
        no_idle = 1'b0;

        req.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
